>>> rtl/tlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlp_pkg: shared types and constants of the traffic light controller
// Lamp phase codes, register indexes, register reset values and widths.
// ----------------------------------------------------------------------------
package tlp_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int DUR_W          = 16;
	localparam int NUM_REGS       = 7;
	localparam int REG_IDX_W      = 3;

	typedef enum logic [1:0] {
		PH_RED    = 2'd0,
		PH_YELLOW = 2'd1,
		PH_GREEN  = 2'd2
	} phase_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_A_GREEN  = 3'd0,
		REG_A_YELLOW = 3'd1,
		REG_A_RED    = 3'd2,
		REG_B_GREEN  = 3'd3,
		REG_B_YELLOW = 3'd4,
		REG_B_RED    = 3'd5,
		REG_WALK     = 3'd6
	} reg_idx_t;

	typedef logic [DUR_W-1:0] dur_t;

	localparam dur_t RST_A_GREEN  = 16'd11000;
	localparam dur_t RST_A_YELLOW = 16'd2000;
	localparam dur_t RST_A_RED    = 16'd7000;
	localparam dur_t RST_B_GREEN  = 16'd5000;
	localparam dur_t RST_B_YELLOW = 16'd2000;
	localparam dur_t RST_B_RED    = 16'd13000;
	localparam dur_t RST_WALK     = 16'd5000;

endpackage

>>> rtl/tlp_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlp channels: valid/ready interfaces of the traffic light controller
// Tick channel carries the button level, light channel the lamp states.
// ----------------------------------------------------------------------------
interface tlp_in_if;
	logic valid;
	logic ready;
	logic button_level;

	modport source (output valid, output button_level, input ready);
	modport sink (input valid, input button_level, output ready);
endinterface

interface tlp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] road_a_color;
	logic [1:0] road_b_color;
	logic       walk_lamp;

	modport source (output valid, output road_a_color, output road_b_color,
		output walk_lamp, input ready);
	modport sink (input valid, input road_a_color, input road_b_color,
		input walk_lamp, output ready);
endinterface

>>> rtl/two_way_traffic_light_pedestrian_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_traffic_light_pedestrian_top: two road lights with pedestrian walk
//
//   channel  dir  payload                                   handshake
//   tick     in   button_level                              valid/ready
//   lights   out  road_a_color, road_b_color, walk_lamp     valid/ready
//   cfg      in   cfg_index, cfg_data                       cfg_we
//
// One tick is accepted every cycle while lights is not stalled.
// The tick goes through an input register, one pass of timer and phase logic
// updates the state and loads the output register.
// Reset loads the default durations, A green, B red, walk off, timers zero.
// A stall on lights holds the output register; tick still takes one more
// transfer into the input register, if that is empty, before ready drops.
// ----------------------------------------------------------------------------
module two_way_traffic_light_pedestrian_top
	import tlp_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tlp_in_if.sink               tick,
	tlp_out_if.source            lights,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_data
);

	localparam int CMP_W = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;

	typedef logic [TIMER_BITS-1:0] tmr_t;

	localparam tmr_t TMR_MAX = {TIMER_BITS{1'b1}};

	// configuration
	dur_t cfg_q [NUM_REGS];

	// pipeline control and payload
	logic   valid_s1, valid_s2;
	logic   button_s1;
	phase_t a_color_s2, b_color_s2;
	logic   walk_s2;
	logic   adv, fire, in_xfer;

	// controller state
	phase_t a_ph_q, b_ph_q;
	tmr_t   a_tmr_q, b_tmr_q, w_tmr_q;
	logic   walk_q, rp_q, riy_q, serve_a_q, serve_b_q;

	phase_t a_ph_n, b_ph_n;
	tmr_t   a_tmr_n, b_tmr_n, w_tmr_n;
	logic   walk_n, rp_n, riy_n, serve_a_n, serve_b_n;

	tmr_t   a_tmr_t, b_tmr_t, w_tmr_t;
	dur_t   a_dur, b_dur;
	logic   a_done, b_done, w_done, any_yellow;

	function automatic logic reached(input tmr_t t, input dur_t d);
		reached = CMP_W'(t) >= CMP_W'(d);
	endfunction

	function automatic tmr_t sat_inc(input tmr_t t);
		sat_inc = (t == TMR_MAX) ? t : t + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_A_GREEN]  <= RST_A_GREEN;
			cfg_q[REG_A_YELLOW] <= RST_A_YELLOW;
			cfg_q[REG_A_RED]    <= RST_A_RED;
			cfg_q[REG_B_GREEN]  <= RST_B_GREEN;
			cfg_q[REG_B_YELLOW] <= RST_B_YELLOW;
			cfg_q[REG_B_RED]    <= RST_B_RED;
			cfg_q[REG_WALK]     <= RST_WALK;
		end else if (cfg_we && ({1'b0, cfg_index} < (REG_IDX_W+1)'(NUM_REGS))) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// pipeline handshake
	assign adv          = !valid_s2 || lights.ready;
	assign fire         = valid_s1 && adv;
	assign tick.ready   = !valid_s1 || adv;
	assign in_xfer      = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			button_s1 <= tick.button_level;
		end
		if (fire) begin
			a_color_s2 <= a_ph_n;
			b_color_s2 <= b_ph_n;
			walk_s2    <= walk_n;
		end
	end

	assign lights.valid        = valid_s2;
	assign lights.road_a_color = a_color_s2;
	assign lights.road_b_color = b_color_s2;
	assign lights.walk_lamp    = walk_s2;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_ph_q    <= PH_GREEN;
			b_ph_q    <= PH_RED;
			a_tmr_q   <= '0;
			b_tmr_q   <= '0;
			w_tmr_q   <= '0;
			walk_q    <= 1'b0;
			rp_q      <= 1'b0;
			riy_q     <= 1'b0;
			serve_a_q <= 1'b0;
			serve_b_q <= 1'b0;
		end else if (fire) begin
			a_ph_q    <= a_ph_n;
			b_ph_q    <= b_ph_n;
			a_tmr_q   <= a_tmr_n;
			b_tmr_q   <= b_tmr_n;
			w_tmr_q   <= w_tmr_n;
			walk_q    <= walk_n;
			rp_q      <= rp_n;
			riy_q     <= riy_n;
			serve_a_q <= serve_a_n;
			serve_b_q <= serve_b_n;
		end
	end

	// duration of the current phase of each road
	always_comb begin
		unique case (a_ph_q)
			PH_RED:    a_dur = cfg_q[REG_A_RED];
			PH_YELLOW: a_dur = cfg_q[REG_A_YELLOW];
			PH_GREEN:  a_dur = cfg_q[REG_A_GREEN];
			default:   a_dur = cfg_q[REG_A_RED];
		endcase
		unique case (b_ph_q)
			PH_RED:    b_dur = cfg_q[REG_B_RED];
			PH_YELLOW: b_dur = cfg_q[REG_B_YELLOW];
			PH_GREEN:  b_dur = cfg_q[REG_B_GREEN];
			default:   b_dur = cfg_q[REG_B_RED];
		endcase
	end

	assign a_tmr_t    = sat_inc(a_tmr_q);
	assign b_tmr_t    = sat_inc(b_tmr_q);
	assign w_tmr_t    = sat_inc(w_tmr_q);
	assign a_done     = reached(a_tmr_t, a_dur);
	assign b_done     = reached(b_tmr_t, b_dur);
	assign w_done     = reached(w_tmr_t, cfg_q[REG_WALK]);
	assign any_yellow = (a_ph_q == PH_YELLOW) || (b_ph_q == PH_YELLOW);

	// next state for one tick
	always_comb begin
		a_ph_n    = a_ph_q;
		b_ph_n    = b_ph_q;
		a_tmr_n   = a_tmr_t;
		b_tmr_n   = b_tmr_t;
		w_tmr_n   = w_tmr_t;
		walk_n    = walk_q;
		rp_n      = rp_q;
		riy_n     = riy_q;
		serve_a_n = serve_a_q;
		serve_b_n = serve_b_q;

		priority if (any_yellow && button_s1 && !rp_q && !riy_q) begin
			riy_n = 1'b1;
		end else if (button_s1 && !riy_q && !rp_q) begin
			rp_n = 1'b1;
		end else if (serve_a_q || serve_b_q) begin
			if (w_done) begin
				serve_a_n = 1'b0;
				serve_b_n = 1'b0;
				rp_n      = 1'b0;
				walk_n    = 1'b0;
				a_tmr_n   = '0;
				b_tmr_n   = '0;
				if (serve_a_q) begin
					a_ph_n = PH_GREEN;
				end else begin
					b_ph_n = PH_GREEN;
				end
			end
		end else begin
			// road a first; road b sees the request flags road a leaves
			if (a_done) begin
				unique case (a_ph_q)
					PH_RED: begin
						if (rp_q) begin
							serve_a_n = 1'b1;
							walk_n    = 1'b1;
							w_tmr_n   = '0;
						end else begin
							if (riy_q) begin
								riy_n = 1'b0;
								rp_n  = 1'b1;
							end
							a_ph_n  = PH_GREEN;
							a_tmr_n = '0;
						end
					end
					PH_YELLOW: begin
						a_ph_n  = PH_RED;
						a_tmr_n = '0;
					end
					PH_GREEN: begin
						a_ph_n  = PH_YELLOW;
						a_tmr_n = '0;
					end
					default: begin
						a_ph_n  = PH_YELLOW;
						a_tmr_n = '0;
					end
				endcase
			end
			if (b_done) begin
				unique case (b_ph_q)
					PH_RED: begin
						if (rp_n) begin
							serve_b_n = 1'b1;
							walk_n    = 1'b1;
							w_tmr_n   = '0;
						end else begin
							if (riy_n) begin
								riy_n = 1'b0;
								rp_n  = 1'b1;
							end
							b_ph_n  = PH_GREEN;
							b_tmr_n = '0;
						end
					end
					PH_YELLOW: begin
						b_ph_n  = PH_RED;
						b_tmr_n = '0;
					end
					PH_GREEN: begin
						b_ph_n  = PH_YELLOW;
						b_tmr_n = '0;
					end
					default: begin
						b_ph_n  = PH_YELLOW;
						b_tmr_n = '0;
					end
				endcase
			end
		end
	end

endmodule

>>> bench/tb_two_way_traffic_light_pedestrian_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_way_traffic_light_pedestrian_top: regression of the traffic light top
// Sends button ticks with random gaps and output stalls, rewrites the phase
// durations between runs, and checks every lamp transfer in order against a
// tick-by-tick model of the road, walk and request logic.
// ----------------------------------------------------------------------------
module tb_two_way_traffic_light_pedestrian_top;
	import tlp_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int MAX_REPORTS    = 10;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef logic [TIMER_BITS_DEF-1:0] count_t;

	typedef struct packed {
		phase_t road_a;
		phase_t road_b;
		logic   walk;
	} lamps_t;

	class lamp_scoreboard;
		dur_t   green_len[2];
		dur_t   yellow_len[2];
		dur_t   red_len[2];
		dur_t   walk_len;
		phase_t phase[2];
		count_t road_timer[2];
		count_t walk_timer;
		bit     walk_on;
		bit     req_pending;
		bit     req_noted;
		bit     serving[2];
		lamps_t lamps_due[$];
		int     mismatches;

		function new();
			green_len   = '{RST_A_GREEN, RST_B_GREEN};
			yellow_len  = '{RST_A_YELLOW, RST_B_YELLOW};
			red_len     = '{RST_A_RED, RST_B_RED};
			walk_len    = RST_WALK;
			phase       = '{PH_GREEN, PH_RED};
			road_timer  = '{'0, '0};
			walk_timer  = '0;
			walk_on     = 1'b0;
			req_pending = 1'b0;
			req_noted   = 1'b0;
			serving     = '{1'b0, 1'b0};
			mismatches  = 0;
		endfunction

		function void set_duration(logic [REG_IDX_W-1:0] idx, dur_t value);
			case (idx)
				REG_A_GREEN:  green_len[0]  = value;
				REG_A_YELLOW: yellow_len[0] = value;
				REG_A_RED:    red_len[0]    = value;
				REG_B_GREEN:  green_len[1]  = value;
				REG_B_YELLOW: yellow_len[1] = value;
				REG_B_RED:    red_len[1]    = value;
				REG_WALK:     walk_len      = value;
				default: ;
			endcase
		endfunction

		function count_t bump(count_t t);
			return (t == '1) ? t : t + 1'b1;
		endfunction

		function void road_step(int r);
			case (phase[r])
				PH_RED: begin
					if (road_timer[r] >= red_len[r]) begin
						if (req_pending) begin
							// red stays until the walk service ends
							serving[r] = 1'b1;
							walk_on    = 1'b1;
							walk_timer = '0;
						end else begin
							if (req_noted) begin
								req_noted   = 1'b0;
								req_pending = 1'b1;
							end
							phase[r]      = PH_GREEN;
							road_timer[r] = '0;
						end
					end
				end
				PH_YELLOW: begin
					if (road_timer[r] >= yellow_len[r]) begin
						phase[r]      = PH_RED;
						road_timer[r] = '0;
					end
				end
				default: begin
					if (road_timer[r] >= green_len[r]) begin
						phase[r]      = PH_YELLOW;
						road_timer[r] = '0;
					end
				end
			endcase
		endfunction

		function void end_walk(int r);
			if (walk_timer >= walk_len) begin
				serving     = '{1'b0, 1'b0};
				req_pending = 1'b0;
				walk_on     = 1'b0;
				phase[r]    = PH_GREEN;
				road_timer  = '{'0, '0};
			end
		endfunction

		function void note_tick(logic button);
			bit any_yellow;
			any_yellow    = (phase[0] == PH_YELLOW) || (phase[1] == PH_YELLOW);
			road_timer[0] = bump(road_timer[0]);
			road_timer[1] = bump(road_timer[1]);
			walk_timer    = bump(walk_timer);
			if (button && any_yellow && !req_pending && !req_noted) begin
				req_noted = 1'b1;
			end else if (button && !req_pending && !req_noted) begin
				req_pending = 1'b1;
			end else if (serving[0]) begin
				end_walk(0);
			end else if (serving[1]) begin
				end_walk(1);
			end else begin
				road_step(0);
				road_step(1);
			end
			lamps_due.push_back('{phase[0], phase[1], walk_on});
		endfunction

		function void check_lights(logic [1:0] a, logic [1:0] b, logic w);
			lamps_t want;
			if (lamps_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] lamp transfer with none expected: a=%0d b=%0d walk=%0b",
						$time, a, b, w);
				return;
			end
			want = lamps_due.pop_front();
			if (a !== want.road_a || b !== want.road_b || w !== want.walk) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] lamp mismatch: expected a=%0d b=%0d walk=%0b, got a=%0d b=%0d walk=%0b",
						$time, want.road_a, want.road_b, want.walk, a, b, w);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	dur_t                 cfg_data;
	bit                   quiet = 1'b0;
	int                   idle_cycles = 0;
	lamp_scoreboard       lamp_sb;

	tlp_in_if  tick_ch ();
	tlp_out_if lights_ch ();

	two_way_traffic_light_pedestrian_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.lights    (lights_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic dur_t pick_duration();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return '0;
		if (roll < 80)
			return dur_t'($urandom_range(1, 6));
		if (roll < 95)
			return dur_t'($urandom_range(7, 20));
		return dur_t'($urandom_range(21, 60));
	endfunction

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, dur_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		lamp_sb.set_duration(idx, value);
	endtask

	task automatic send_tick(logic button);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid        <= 1'b1;
		tick_ch.button_level <= button;
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
	endtask

	// first edge lets the last transfer reach the scoreboard
	task automatic wait_for_lamps();
		tick_ch.valid <= 1'b0;
		do @(posedge clk); while (lamp_sb.lamps_due.size() != 0);
	endtask

	// presses start with odds 1 in press_odds, some are held for a few ticks
	task automatic run_ticks(int count, int press_odds, int pause_at);
		int   held;
		logic button;
		held = 0;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_for_lamps();
			button = 1'b0;
			if (held > 0) begin
				button = 1'b1;
				held--;
			end else if ($urandom_range(1, press_odds) == 1) begin
				button = 1'b1;
				held   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
			end
			send_tick(button);
		end
	endtask

	always @(posedge clk) begin
		if (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1)
			lamp_sb.note_tick(tick_ch.button_level);
		if (lights_ch.valid === 1'b1 && lights_ch.ready === 1'b1)
			lamp_sb.check_lights(lights_ch.road_a_color, lights_ch.road_b_color,
				lights_ch.walk_lamp);
		if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
			(lights_ch.valid === 1'b1 && lights_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// output side: runs of ready with random stalls in between
	initial begin
		int left;
		bit on;
		left = 0;
		on   = 1'b0;
		lights_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left > 0) begin
				left--;
			end else if (on) begin
				left = pick_gap();
				if (left > 0) begin
					on = 1'b0;
					lights_ch.ready <= 1'b0;
					left--;
				end else begin
					left = $urandom_range(0, 11);
				end
			end else begin
				on = 1'b1;
				lights_ch.ready <= 1'b1;
				left = $urandom_range(0, 11);
			end
		end
	end

	initial begin
		do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
		$display("two_way_traffic_light_pedestrian_top regression: fail");
		$finish;
	end

	initial begin
		logic opening[24];
		opening = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
			1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
			1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
		lamp_sb = new();
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_A_GREEN;
		cfg_data             <= '0;
		tick_ch.valid        <= 1'b0;
		tick_ch.button_level <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// two ticks on reset durations, then a setup where a request is
		// pending as both reds run out in the same tick; later a press lands
		// in yellow and is promoted when A's red ends while B's red also ends
		send_tick(1'b0);
		send_tick(1'b0);
		wait_for_lamps();
		write_reg(REG_A_GREEN, 16'd3);
		write_reg(REG_A_YELLOW, 16'd1);
		write_reg(REG_A_RED, 16'd1);
		write_reg(REG_B_GREEN, 16'd1);
		write_reg(REG_B_YELLOW, 16'd1);
		write_reg(REG_B_RED, 16'd6);
		write_reg(REG_WALK, 16'd2);
		foreach (opening[i])
			send_tick(opening[i]);

		for (int p = 0; p < 8; p++) begin
			wait_for_lamps();
			quiet = (p % 4 == 3);
			for (int r = REG_A_GREEN; r <= REG_WALK; r++)
				write_reg(REG_IDX_W'(r), pick_duration());
			if (p == 1) begin
				// zero durations last a single tick, unless a new press is noted in a zero yellow
				write_reg(REG_A_YELLOW, '0);
				write_reg(REG_WALK, '0);
			end
			if (p == 2)
				write_reg(REG_SPARE, dur_t'($urandom()));
			run_ticks(80, $urandom_range(2, 12), (p == 5) ? 40 : -1);
		end

		// longest durations: lamps hold their phase
		wait_for_lamps();
		quiet = 1'b1;
		for (int r = REG_A_GREEN; r <= REG_WALK; r++)
			write_reg(REG_IDX_W'(r), '1);
		run_ticks(40, 8, -1);

		wait_for_lamps();
		repeat (8) @(posedge clk);
		if (lamp_sb.mismatches == 0 && lamp_sb.lamps_due.size() == 0)
			$display("two_way_traffic_light_pedestrian_top regression: pass");
		else
			$display("two_way_traffic_light_pedestrian_top regression: fail");
		$finish;
	end

endmodule
